/* rtl/core/pgt_pkg.sv */
// Shared types, codes and helpers for the four-level page table mapper.
`timescale 1ns / 1ps

package pgt_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int ADDR_W            = 40;
    localparam int ENTRY_W           = 43;
    localparam int VPAGE_W           = 36;

    localparam logic [1:0] MODE_MAP   = 2'd1;
    localparam logic [1:0] MODE_UNMAP = 2'd2;

    localparam logic [IDX_W-1:0] RESERVED_L4_LO = 9'd256;
    localparam logic [IDX_W-1:0] RESERVED_L4_HI = 9'd257;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_MAPPED = 3'd1,
        ST_CONFLICT   = 3'd2,
        ST_RESERVED   = 3'd3,
        ST_EXHAUSTED  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_RESP
    } t_state;

    // Pick the 9-bit table index of one level, level 0 being the root.
    function automatic logic [IDX_W-1:0] level_index(input logic [VPAGE_W-1:0] vp,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = vp[35:27];
            2'd1:    idx = vp[26:18];
            2'd2:    idx = vp[17:9];
            default: idx = vp[8:0];
        endcase
        return idx;
    endfunction

    // Build a present entry from an address and attributes.
    function automatic logic [ENTRY_W-1:0] make_entry(input logic [ADDR_W-1:0] addr,
                                                      input logic user,
                                                      input logic rw);
        return {addr, user, rw, 1'b1};
    endfunction

endpackage

/* rtl/core/pgt_store.sv */
// Table store: one write port and one registered read port.
`timescale 1ns / 1ps

module pgt_store #(
    parameter int DEPTH  = 32768,
    parameter int AW     = 15
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [pgt_pkg::ENTRY_W-1:0]   i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [pgt_pkg::ENTRY_W-1:0]   o_rdata
);

    logic [pgt_pkg::ENTRY_W-1:0] r_mem [DEPTH];

    // Write one word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read word.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/four_level_page_table_mapper.sv */
// Top level: sequencer that walks, maps and unmaps pages in the table store.
`timescale 1ns / 1ps

// Usage
//   Command channel: raise start with the item fields; the word is taken at a
//   clock edge where start is high and busy is low. busy stays high until the
//   result has been shown.
//   Result channel: o_done is high for exactly one cycle with o_status,
//   o_frame_out, o_freed_valid and o_range_done; the receiver cannot stall.
//   Walk: each level is read by an address step and then a check of the
//   registered word. A successful map then writes the three directory levels
//   and the leaf, and the result is shown after the walk or the last write.
//   One item is in flight at a time. The next word is taken only once the
//   sequencer is back in idle after the result.
//   Reset: i_rst_n low clears the sequencer and the table allocator. After
//   reset a clearing pass writes zero to all TABLE_FRAMES*512 words; busy
//   is high until it ends. New tables need no clearing later, since tables
//   past the allocator have not been written since the pass.
module four_level_page_table_mapper #(
    parameter int TABLE_FRAMES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   i_mode,
    input  logic         i_foreign,
    input  logic [35:0]  i_virt_page,
    input  logic [39:0]  i_phys_page,
    input  logic         i_user,
    input  logic         i_read_write,
    input  logic         i_release_req,
    input  logic         i_last_page,
    output logic         o_done,
    output logic [2:0]   o_status,
    output logic [39:0]  o_frame_out,
    output logic         o_freed_valid,
    output logic         o_range_done
);

    localparam int TW    = $clog2(TABLE_FRAMES);
    localparam int NW    = $clog2(TABLE_FRAMES + 1);
    localparam int AW    = TW + pgt_pkg::IDX_W;
    localparam int DEPTH = TABLE_FRAMES * pgt_pkg::ENTRIES_PER_TABLE;
    localparam int EW    = pgt_pkg::ENTRY_W;
    localparam int XW    = pgt_pkg::ADDR_W;

    pgt_pkg::t_state r_state, n_state;

    logic [AW-1:0]   r_clr, n_clr;
    logic [NW-1:0]   r_next, n_next;
    logic [1:0]      r_lvl, n_lvl;
    logic [1:0]      r_walk, n_walk;
    logic [TW-1:0]   r_cur, n_cur;
    logic [TW-1:0]   r_path [4];
    logic [TW-1:0]   n_path [4];

    logic [1:0]      r_mode;
    logic [35:0]     r_vp;
    logic [39:0]     r_phys;
    logic            r_user, r_rw, r_rel, r_last;

    logic [2:0]      r_status, n_status;
    logic [39:0]     r_frame, n_frame;
    logic            r_freed, n_freed;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [EW-1:0]   mem_wdata, mem_rdata;

    logic [XW-1:0]   e_addr;
    logic            e_child_ok;
    logic            walk_stop;
    logic [1:0]      needed;
    logic [NW:0]     alloc_end;
    logic [pgt_pkg::IDX_W-1:0] idx_l4, idx_cur, idx_wr;
    logic [TW-1:0]   wr_child;
    logic            wr_alloc;

    pgt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Decode the word read for the current level.
    assign e_addr     = mem_rdata[EW-1:3];
    assign e_child_ok = mem_rdata[0] && (e_addr < XW'(TABLE_FRAMES));
    assign walk_stop  = (r_lvl == 2'd3) || !e_child_ok;
    assign needed     = 2'd3 - r_lvl;
    assign alloc_end  = {1'b0, r_next} + (NW + 1)'(needed);
    assign idx_l4     = pgt_pkg::level_index(r_vp, 2'd0);
    assign idx_cur    = pgt_pkg::level_index(r_vp, r_lvl);
    assign idx_wr     = pgt_pkg::level_index(r_vp, r_lvl);
    assign wr_alloc   = (r_lvl >= r_walk);
    assign wr_child   = wr_alloc ? r_next[TW-1:0] : r_path[r_lvl + 2'd1];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pgt_pkg::S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = pgt_pkg::S_IDLE;
            end
            pgt_pkg::S_IDLE: begin
                if (start) n_state = pgt_pkg::S_READ;
            end
            pgt_pkg::S_READ: begin
                n_state = pgt_pkg::S_CHECK;
            end
            pgt_pkg::S_CHECK: begin
                if (!walk_stop) begin
                    n_state = pgt_pkg::S_READ;
                end else if (r_mode == pgt_pkg::MODE_MAP
                             && idx_l4 != pgt_pkg::RESERVED_L4_LO
                             && idx_l4 != pgt_pkg::RESERVED_L4_HI
                             && !(r_lvl == 2'd3 && mem_rdata[0] && e_addr != r_phys)
                             && alloc_end <= (NW + 1)'(TABLE_FRAMES)) begin
                    n_state = pgt_pkg::S_WRITE;
                end else begin
                    n_state = pgt_pkg::S_RESP;
                end
            end
            pgt_pkg::S_WRITE: begin
                if (r_lvl == 2'd3) n_state = pgt_pkg::S_RESP;
            end
            pgt_pkg::S_RESP: begin
                n_state = pgt_pkg::S_IDLE;
            end
            default: n_state = pgt_pkg::S_IDLE;
        endcase
    end

    // Datapath and store port controls.
    always_comb begin
        n_clr     = r_clr;
        n_next    = r_next;
        n_lvl     = r_lvl;
        n_walk    = r_walk;
        n_cur     = r_cur;
        n_path    = r_path;
        n_status  = r_status;
        n_frame   = r_frame;
        n_freed   = r_freed;
        mem_we    = 1'b0;
        mem_waddr = {r_cur, idx_cur};
        mem_wdata = '0;
        mem_raddr = {r_cur, idx_cur};
        case (r_state)
            pgt_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
            end
            pgt_pkg::S_IDLE: begin
                n_lvl     = 2'd0;
                n_cur     = TW'(i_foreign);
                n_path[0] = TW'(i_foreign);
            end
            pgt_pkg::S_CHECK: begin
                n_status = pgt_pkg::ST_OK;
                n_frame  = '0;
                n_freed  = 1'b0;
                if (!walk_stop) begin
                    // Descend into the child table.
                    n_path[r_lvl + 2'd1] = e_addr[TW-1:0];
                    n_cur                = e_addr[TW-1:0];
                    n_lvl                = r_lvl + 2'd1;
                end else if (r_mode == pgt_pkg::MODE_MAP) begin
                    n_walk = r_lvl;
                    n_lvl  = 2'd0;
                    n_cur  = r_path[0];
                    if (idx_l4 == pgt_pkg::RESERVED_L4_LO
                        || idx_l4 == pgt_pkg::RESERVED_L4_HI) begin
                        n_status = pgt_pkg::ST_RESERVED;
                    end else if (r_lvl == 2'd3 && mem_rdata[0] && e_addr != r_phys) begin
                        n_status = pgt_pkg::ST_CONFLICT;
                    end else if (alloc_end > (NW + 1)'(TABLE_FRAMES)) begin
                        n_status = pgt_pkg::ST_EXHAUSTED;
                    end
                end else if (r_lvl != 2'd3 || !mem_rdata[0]) begin
                    n_status = pgt_pkg::ST_NOT_MAPPED;
                end else if (r_mode == pgt_pkg::MODE_UNMAP) begin
                    // Drop the leaf present bit, keep the frame.
                    mem_we    = 1'b1;
                    mem_wdata = {mem_rdata[EW-1:1], 1'b0};
                    if (r_rel) begin
                        n_frame = e_addr;
                        n_freed = 1'b1;
                    end
                end else begin
                    n_frame = e_addr;
                end
            end
            pgt_pkg::S_WRITE: begin
                mem_we = 1'b1;
                if (r_lvl == 2'd3) begin
                    mem_wdata = pgt_pkg::make_entry(r_phys, r_user, r_rw);
                end else begin
                    // Link the path, allocating missing tables.
                    mem_wdata = pgt_pkg::make_entry(XW'(wr_child), r_user, r_rw);
                    n_cur     = wr_child;
                    n_lvl     = r_lvl + 2'd1;
                    if (wr_alloc) n_next = r_next + NW'(1);
                end
                mem_waddr = {r_cur, idx_wr};
            end
            default: begin
            end
        endcase
    end

    // Handshake and result outputs.
    always_comb begin
        busy          = (r_state != pgt_pkg::S_IDLE);
        o_done        = (r_state == pgt_pkg::S_RESP);
        o_status      = r_status;
        o_frame_out   = r_frame;
        o_freed_valid = r_freed;
        o_range_done  = r_last;
    end

    // Advance control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgt_pkg::S_CLEAR;
            r_clr   <= '0;
            r_next  <= NW'(2);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_next  <= n_next;
        end
    end

    // Hold walk and result words.
    always_ff @(posedge i_clk) begin
        r_lvl    <= n_lvl;
        r_walk   <= n_walk;
        r_cur    <= n_cur;
        r_path   <= n_path;
        r_status <= n_status;
        r_frame  <= n_frame;
        r_freed  <= n_freed;
        if (r_state == pgt_pkg::S_IDLE && start) begin
            r_mode <= i_mode;
            r_vp   <= i_virt_page;
            r_phys <= i_phys_page;
            r_user <= i_user;
            r_rw   <= i_read_write;
            r_rel  <= i_release_req;
            r_last <= i_last_page;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NW + 1)'(r_next) <= (NW + 1)'(TABLE_FRAMES))
        else $error("table allocator past the store");

    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_freed_valid)
            |-> (o_status == pgt_pkg::ST_OK && r_mode == pgt_pkg::MODE_UNMAP))
        else $error("freed frame without a successful unmap");

    a_done_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == pgt_pkg::S_CHECK || $past(r_state) == pgt_pkg::S_WRITE))
        else $error("result shown without a walk");

endmodule
